// ===== src/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, codes and tables of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Grid limits and tab spacing
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;
    localparam int TAB_STOP    = 4;

    // Character codes with cursor meaning
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // Command codes
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_SCROLL = 1'b1;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam logic [1:0]  REG_GRID_COLUMNS = 2'd0;
    localparam logic [1:0]  REG_GRID_ROWS    = 2'd1;
    localparam logic [1:0]  REG_TEXT_COLOR   = 2'd2;

    // Reset values of the registers
    localparam logic [7:0] GRID_COLUMNS_RST = 8'd80;
    localparam logic [6:0] GRID_ROWS_RST    = 7'd25;
    localparam logic [7:0] TEXT_COLOR_RST   = 8'h07;

    // Effective grid caps at the field widths
    localparam logic [7:0] COL_LIMIT = (MAX_COLUMNS - 1 > 255) ? 8'd255 : 8'(MAX_COLUMNS - 1);
    localparam logic [6:0] ROW_LIMIT = (MAX_ROWS - 1 > 127) ? 7'd127 : 7'(MAX_ROWS - 1);

    // One output command
    typedef struct packed {
        logic        command;
        logic [7:0]  cell_column;
        logic [6:0]  cell_row;
        logic [7:0]  glyph_code;
        logic [23:0] foreground_rgb;
        logic [23:0] background_rgb;
        logic        last_of_run;
    } t_result;

    // Next tab stop for every column, built at elaboration
    typedef logic [8:0] t_tab_row [256];

    function automatic t_tab_row f_tab_next();
        t_tab_row tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = 9'(i - (i % TAB_STOP) + TAB_STOP);
        end
        return tbl;
    endfunction

    localparam t_tab_row TAB_NEXT = f_tab_next();

    // 16-entry color palette, 0xRRGGBB
    function automatic logic [23:0] f_palette(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0000AA;
            4'd2:    rgb = 24'h00AA00;
            4'd3:    rgb = 24'h00AAAA;
            4'd4:    rgb = 24'hAA0000;
            4'd5:    rgb = 24'hAA00AA;
            4'd6:    rgb = 24'hAA5500;
            4'd7:    rgb = 24'hAAAAAA;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'h5555FF;
            4'd10:   rgb = 24'h55FF55;
            4'd11:   rgb = 24'h55FFFF;
            4'd12:   rgb = 24'hFF5555;
            4'd13:   rgb = 24'hFF55FF;
            4'd14:   rgb = 24'hFFFF55;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

// ===== src/text_console_cursor_engine_top.sv =====
// Text console cursor engine: each character word on the slave stream moves a
// text cursor over a grid set by the configuration registers and yields zero,
// one or two command words (a cell draw, then a scroll-up) on the master
// stream, the final one flagged by tlast. Characters that cause at most one
// command are taken one per cycle while the master stream accepts; a
// character that causes a draw and a scroll holds the next one back until
// the single master port has drained the three-entry result queue to one
// entry. With an empty queue a command is presented once its character has
// passed the input register and the cursor update has put it into the queue.
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Cursor update, command build and output queue of the text console.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [tcce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    // character stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] char_code
    // command stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] cell_column, [14:8] cell_row, [22:15] glyph_code,
    // [46:23] foreground_rgb, [70:47] background_rgb, [71] zero fill
    output logic [71:0]                   o_m_tdata,
    output logic                          o_m_tuser,   // [0] command
    output logic                          o_m_tlast    // last_of_run
);
    import tcce_pkg::*;

    localparam int QDEPTH = 3;

    // configuration registers
    logic [7:0] r_grid_columns;
    logic [6:0] r_grid_rows;
    logic [7:0] r_text_color;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;

    // cursor state
    logic [7:0] r_cur_col;
    logic [6:0] r_cur_row;

    // result queue
    t_result    r_q [QDEPTH];
    t_result    n_q [QDEPTH];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    logic        fire;
    logic        pop;
    logic [7:0]  cols;
    logic [6:0]  rows;
    logic [7:0]  col_c;
    logic [6:0]  row_c;
    logic [7:0]  n_col;
    logic [7:0]  n_row;
    logic [6:0]  fin_row;
    logic [8:0]  tab_col;
    logic [8:0]  inc_col;
    logic [23:0] fg_rgb;
    logic [23:0] bg_rgb;
    logic        draw_vld;
    logic        scroll_vld;
    t_result     draw_res;
    t_result     scroll_res;

    // handshakes
    assign fire       = r_in_valid && (r_cnt <= 2'd1);
    assign o_s_tready = !r_in_valid || fire;
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign pop        = o_m_tvalid && i_m_tready;

    // effective grid size: zero acts as one, capped at the limits
    always_comb begin
        cols = (r_grid_columns == 8'd0) ? 8'd1 : r_grid_columns;
        if (cols > COL_LIMIT) begin
            cols = COL_LIMIT;
        end
        rows = (r_grid_rows == 7'd0) ? 7'd1 : r_grid_rows;
        if (rows > ROW_LIMIT) begin
            rows = ROW_LIMIT;
        end
    end

    assign fg_rgb = f_palette(r_text_color[3:0]);
    assign bg_rgb = f_palette(r_text_color[7:4]);

    // clamp the cursor into the grid, then apply the character
    always_comb begin
        col_c    = (r_cur_col >= cols) ? cols - 8'd1 : r_cur_col;
        row_c    = (r_cur_row >= rows) ? rows - 7'd1 : r_cur_row;
        n_col    = col_c;
        n_row    = {1'b0, row_c};
        tab_col  = TAB_NEXT[col_c];
        inc_col  = {1'b0, col_c} + 9'd1;
        draw_vld = 1'b0;
        draw_res = '0;
        draw_res.command        = CMD_DRAW;
        draw_res.foreground_rgb = fg_rgb;
        draw_res.background_rgb = bg_rgb;
        case (r_in_char)
            CH_NEWLINE: begin
                n_col = 8'd0;
                n_row = {1'b0, row_c} + 8'd1;
            end
            CH_RETURN: begin
                n_col = 8'd0;
            end
            CH_TAB: begin
                if (tab_col >= {1'b0, cols}) begin
                    n_col = 8'd0;
                    n_row = {1'b0, row_c} + 8'd1;
                end else begin
                    n_col = tab_col[7:0];
                end
            end
            CH_BACKSPACE: begin
                // top-left cell: stay put and erase it
                if (col_c != 8'd0) begin
                    n_col = col_c - 8'd1;
                end else if (row_c != 7'd0) begin
                    n_col = cols - 8'd1;
                    n_row = {1'b0, row_c - 7'd1};
                end
                draw_vld             = 1'b1;
                draw_res.cell_column = n_col;
                draw_res.cell_row    = n_row[6:0];
                draw_res.glyph_code  = CH_SPACE;
            end
            default: begin
                draw_vld             = 1'b1;
                draw_res.cell_column = col_c;
                draw_res.cell_row    = row_c;
                draw_res.glyph_code  = r_in_char;
                if (inc_col >= {1'b0, cols}) begin
                    n_col = 8'd0;
                    n_row = {1'b0, row_c} + 8'd1;
                end else begin
                    n_col = inc_col[7:0];
                end
            end
        endcase

        // past the last row: scroll and hold on the last row
        scroll_vld = (n_row >= {1'b0, rows});
        fin_row    = scroll_vld ? rows - 7'd1 : n_row[6:0];
        scroll_res = '0;
        scroll_res.command        = CMD_SCROLL;
        scroll_res.background_rgb = bg_rgb;
        scroll_res.last_of_run    = 1'b1;
        draw_res.last_of_run      = !scroll_vld;
    end

    // shift out on pop, append new commands behind the survivors
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_cnt  = r_cnt - 2'd1;
        end
        if (fire && draw_vld) begin
            n_q[n_cnt] = draw_res;
            n_cnt      = n_cnt + 2'd1;
        end
        if (fire && scroll_vld) begin
            n_q[n_cnt] = scroll_res;
            n_cnt      = n_cnt + 2'd1;
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= GRID_COLUMNS_RST;
            r_grid_rows    <= GRID_ROWS_RST;
            r_text_color   <= TEXT_COLOR_RST;
            r_in_valid     <= 1'b0;
            r_cur_col      <= 8'd0;
            r_cur_row      <= 7'd0;
            r_cnt          <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_GRID_COLUMNS: r_grid_columns <= i_cfg_data;
                    REG_GRID_ROWS:    r_grid_rows    <= i_cfg_data[6:0];
                    REG_TEXT_COLOR:   r_text_color   <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (fire) begin
                r_cur_col <= n_col;
                r_cur_row <= fin_row;
            end
            r_cnt <= n_cnt;
        end
    end

    // payload: input word and queue entries
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
        end
        r_q <= n_q;
    end

    // drive the head of the queue
    assign o_m_tdata = {1'b0, r_q[0].background_rgb, r_q[0].foreground_rgb,
                        r_q[0].glyph_code, r_q[0].cell_row, r_q[0].cell_column};
    assign o_m_tuser = r_q[0].command;
    assign o_m_tlast = r_q[0].last_of_run;

`ifndef SYNTH
    // a scroll is always the final command of its character
    a_scroll_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == CMD_SCROLL) |-> o_m_tlast)
        else $error("scroll command without tlast");

    // a scroll carries only the fill color
    a_scroll_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == CMD_SCROLL) |-> (o_m_tdata[46:0] == 47'd0))
        else $error("scroll command with cell fields set");

    // the cursor lands inside the grid after each character
    a_cursor_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_cur_col < $past(cols)) && (r_cur_row < $past(rows)))
        else $error("cursor left the grid");
`endif

endmodule

// ===== verif/text_console_cursor_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top_tb
// Self-checking bench for the text console cursor engine. Character words are
// fed through the slave stream while a local cursor predictor builds the
// draw and scroll commands that each one should produce; the command stream
// is compared field by field in arrival order. Grid size and colors are
// changed between phases while the engine is idle, and both stream sides
// insert random bursts of idle and stall cycles.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top_tb;
    import tcce_pkg::*;

    localparam int         RANDOM_ITEMS    = 1930;
    localparam int         QUIET_ITEMS     = 250;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         WATCHDOG_CYCLES = 2000;
    localparam int         REPORT_LIMIT    = 40;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    // Color lookup, index to 0xRRGGBB
    localparam logic [23:0] PALETTE_RGB [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    // Opening run on the reset grid: erase at top-left, code extremes, tabs
    localparam logic [7:0] OPENING_CHARS [12] = '{
        CH_BACKSPACE, 8'h00, 8'hFF, 8'h41, CH_TAB, CH_TAB,
        CH_BACKSPACE, CH_RETURN, CH_NEWLINE, CH_NEWLINE, CH_NEWLINE, CH_TAB
    };
    // Zero-sized grid: cursor clamps in, each glyph, tab and newline scrolls
    localparam logic [7:0] TINY_GRID_CHARS [7] = '{
        8'h5A, CH_TAB, CH_NEWLINE, CH_RETURN, CH_BACKSPACE, 8'hAA, 8'h55
    };
    // Largest grid
    localparam logic [7:0] WIDE_GRID_CHARS [5] = '{
        CH_TAB, 8'h78, CH_BACKSPACE, CH_BACKSPACE, CH_NEWLINE
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Predictor copy of the registers and the cursor
    logic [7:0]  grid_columns_q = GRID_COLUMNS_RST;
    logic [6:0]  grid_rows_q    = GRID_ROWS_RST;
    logic [7:0]  text_color_q   = TEXT_COLOR_RST;
    logic [7:0]  cursor_col_q   = '0;
    logic [6:0]  cursor_row_q   = '0;

    logic [7:0]  pending_chars [$];
    t_result     expected_cmds [$];
    int          mismatch_count = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          quiet_cycles = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;

    text_console_cursor_engine_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Move the cursor for one character and queue the commands it causes
    task automatic predict_commands(input logic [7:0] ch);
        int          cols;
        int          rows;
        int          col;
        int          row;
        logic [23:0] fg;
        logic [23:0] bg;
        t_result     draw_cmd;
        t_result     scroll_cmd;
        bit          drew;
        bit          scrolled;
        cols = (grid_columns_q == 8'd0) ? 1 : int'(grid_columns_q);
        if (cols > MAX_COLUMNS - 1) cols = MAX_COLUMNS - 1;
        rows = (grid_rows_q == 7'd0) ? 1 : int'(grid_rows_q);
        if (rows > MAX_ROWS - 1) rows = MAX_ROWS - 1;
        fg = PALETTE_RGB[text_color_q[3:0]];
        bg = PALETTE_RGB[text_color_q[7:4]];
        col = int'(cursor_col_q);
        row = int'(cursor_row_q);
        draw_cmd = '0;
        scroll_cmd = '0;
        drew = 1'b0;
        scrolled = 1'b0;
        // pull a cursor left outside a shrunken grid back onto it
        if (col >= cols) col = cols - 1;
        if (row >= rows) row = rows - 1;
        case (ch)
            CH_NEWLINE: begin
                col = 0;
                row++;
            end
            CH_RETURN: begin
                col = 0;
            end
            CH_TAB: begin
                col = col - col % TAB_STOP + TAB_STOP;
                if (col >= cols) begin
                    col = 0;
                    row++;
                end
            end
            CH_BACKSPACE: begin
                if (col > 0) begin
                    col--;
                end else if (row > 0) begin
                    row--;
                    col = cols - 1;
                end
                drew = 1'b1;
                draw_cmd.cell_column = 8'(col);
                draw_cmd.cell_row    = 7'(row);
                draw_cmd.glyph_code  = CH_SPACE;
            end
            default: begin
                drew = 1'b1;
                draw_cmd.cell_column = 8'(col);
                draw_cmd.cell_row    = 7'(row);
                draw_cmd.glyph_code  = ch;
                col++;
                if (col >= cols) begin
                    col = 0;
                    row++;
                end
            end
        endcase
        draw_cmd.command        = CMD_DRAW;
        draw_cmd.foreground_rgb = fg;
        draw_cmd.background_rgb = bg;
        // row ran off the bottom: scroll and hold on the last row
        if (row >= rows) begin
            scrolled = 1'b1;
            scroll_cmd.command        = CMD_SCROLL;
            scroll_cmd.background_rgb = bg;
            scroll_cmd.last_of_run    = 1'b1;
            row = rows - 1;
        end
        draw_cmd.last_of_run = !scrolled;
        if (drew) expected_cmds.push_back(draw_cmd);
        if (scrolled) expected_cmds.push_back(scroll_cmd);
        cursor_col_q = 8'(col);
        cursor_row_q = 7'(row);
    endtask

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    // Drive character words; predict on each accepted one
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_commands(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (src_idle_en && src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_chars.pop_front();
                    if (src_idle_en && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 16);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Stall the command stream in random bursts
    always @(posedge clk) begin
        if (sink_idle_en && sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (sink_idle_en && $urandom_range(0, 6) == 0)
                sink_gap = $urandom_range(1, 16);
        end
    end

    // Compare each command word with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_cmds.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: command expected none got %h user %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
            end else begin
                check_field("command", 24'(expected_cmds[0].command), 24'(m_tuser));
                check_field("cell_column", 24'(expected_cmds[0].cell_column),
                            24'(m_tdata[7:0]));
                check_field("cell_row", 24'(expected_cmds[0].cell_row), 24'(m_tdata[14:8]));
                check_field("glyph_code", 24'(expected_cmds[0].glyph_code),
                            24'(m_tdata[22:15]));
                check_field("foreground_rgb", expected_cmds[0].foreground_rgb,
                            m_tdata[46:23]);
                check_field("background_rgb", expected_cmds[0].background_rgb,
                            m_tdata[70:47]);
                check_field("last_of_run", 24'(expected_cmds[0].last_of_run), 24'(m_tlast));
                void'(expected_cmds.pop_front());
            end
        end
    end

    // Stop a run that no longer moves any word
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Write one register and track it in the predictor; engine must be idle
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GRID_COLUMNS: grid_columns_q = val;
            REG_GRID_ROWS:    grid_rows_q    = val[6:0];
            REG_TEXT_COLOR:   text_color_q   = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait for every word to be sent and every command to arrive
    task automatic drain_and_settle();
        while (pending_chars.size() != 0 || s_tvalid || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        int         sent;
        int         phase_len;
        int         pick;
        logic [7:0] cols_val;
        logic [7:0] rows_val;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed runs
        @(negedge clk);
        foreach (OPENING_CHARS[k]) pending_chars.push_back(OPENING_CHARS[k]);
        drain_and_settle();
        write_reg(REG_GRID_COLUMNS, 8'd0);
        write_reg(REG_GRID_ROWS, 8'd0);
        write_reg(REG_TEXT_COLOR, 8'hF0);
        write_reg(REG_UNUSED, 8'hFF);
        @(negedge clk);
        foreach (TINY_GRID_CHARS[k]) pending_chars.push_back(TINY_GRID_CHARS[k]);
        drain_and_settle();
        write_reg(REG_GRID_COLUMNS, 8'd255);
        write_reg(REG_GRID_ROWS, 8'hFF);
        write_reg(REG_TEXT_COLOR, 8'h0F);
        @(negedge clk);
        foreach (WIDE_GRID_CHARS[k]) pending_chars.push_back(WIDE_GRID_CHARS[k]);
        drain_and_settle();

        // Random phases, each on a fresh grid; the last one without idling
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (RANDOM_ITEMS - sent <= QUIET_ITEMS) begin
                phase_len = RANDOM_ITEMS - sent;
                src_idle_en = 1'b0;
                sink_idle_en = 1'b0;
            end else begin
                phase_len = $urandom_range(60, 180);
                if (phase_len > RANDOM_ITEMS - QUIET_ITEMS - sent)
                    phase_len = RANDOM_ITEMS - QUIET_ITEMS - sent;
                src_idle_en = ($urandom_range(0, 2) != 0);
                sink_idle_en = ($urandom_range(0, 2) != 0);
            end

            // mostly small grids so wraps and scrolls are frequent
            pick = $urandom_range(0, 19);
            if (pick == 0)       cols_val = 8'd0;
            else if (pick == 1)  cols_val = 8'd255;
            else if (pick == 2)  cols_val = 8'd80;
            else if (pick < 11)  cols_val = 8'($urandom_range(1, 6));
            else                 cols_val = 8'($urandom_range(1, 40));
            pick = $urandom_range(0, 19);
            if (pick == 0)       rows_val = 8'd0;
            else if (pick == 1)  rows_val = 8'd127;
            else if (pick == 2)  rows_val = 8'd25;
            else if (pick < 12)  rows_val = 8'($urandom_range(1, 4));
            else                 rows_val = 8'($urandom_range(1, 30));
            rows_val[7] = 1'($urandom_range(0, 1));
            write_reg(REG_GRID_COLUMNS, cols_val);
            write_reg(REG_GRID_ROWS, rows_val);
            write_reg(REG_TEXT_COLOR, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));

            @(negedge clk);
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)       pending_chars.push_back(8'($urandom_range(0, 255)));
                else if (pick < 55)  pending_chars.push_back(CH_NEWLINE);
                else if (pick < 63)  pending_chars.push_back(CH_RETURN);
                else if (pick < 78)  pending_chars.push_back(CH_TAB);
                else                 pending_chars.push_back(CH_BACKSPACE);
            end
            drain_and_settle();
            sent += phase_len;
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
